// ===== design/topological_sort_engine_top_defines.svh =====
// ----------------------------------------------------------------------------
// topological_sort_engine_top_defines
// Assertion macros used by the sort engine (tse_sort).
// ----------------------------------------------------------------------------
`ifndef TOPOLOGICAL_SORT_ENGINE_TOP_DEFINES_SVH
`define TOPOLOGICAL_SORT_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTH
`define TSE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tse assertion failed");
`define TSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tse assertion failed");
`else
`define TSE_ASSERT_IMPL(lbl, ante, cons)
`define TSE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/tse_pkg.sv =====
// ----------------------------------------------------------------------------
// tse_pkg
// Types and constants of the topological sort engine.
// ----------------------------------------------------------------------------
package tse_pkg;

  localparam int NodeCountDefault = 16;
  localparam int NodeIdW          = 4;
  localparam int NodeIdLimit      = 2 ** NodeIdW;
  localparam int DepW             = 16;
  localparam int StatusW          = 2;
  localparam int CmdQueueDepth    = 2;
  localparam int ResQueueDepth    = 2;

  localparam logic OpAdd   = 1'b0;
  localparam logic OpBuild = 1'b1;

  localparam logic [StatusW-1:0] StatusSorted     = 2'd0;
  localparam logic [StatusW-1:0] StatusUnresolved = 2'd1;
  localparam logic [StatusW-1:0] StatusEmpty      = 2'd2;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_BUILD,
    CMD_DROP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [NodeIdW-1:0]  node_id;
    logic [DepW-1:0]     dep_mask;
  } cmd_t;

  typedef struct packed {
    logic [NodeIdW-1:0]  order_node;
    logic [StatusW-1:0]  status;
    logic                last;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_POP
  } sort_state_e;

endpackage

// ===== design/tse_fifo.sv =====
// ----------------------------------------------------------------------------
// tse_fifo
// Small first-in first-out queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module tse_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             full_o,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             empty_o,
  input  logic             rd_pop_i
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_valid_i && !full_o;
  assign do_rd     = rd_pop_i && !empty_o;
  assign rd_data_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entries_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== design/tse_front.sv =====
// ----------------------------------------------------------------------------
// tse_front
// Accepts items, classifies them and queues them for the sort engine.
// ----------------------------------------------------------------------------
module tse_front #(
  parameter int NODE_COUNT = tse_pkg::NodeCountDefault,
  parameter int DEPTH      = tse_pkg::CmdQueueDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic                         operation_i,
  input  logic [tse_pkg::NodeIdW-1:0]  node_id_i,
  input  logic [tse_pkg::DepW-1:0]     dep_mask_i,
  output logic                         cmd_valid_o,
  output tse_pkg::cmd_t                cmd_o,
  input  logic                         cmd_pop_i
);

  localparam int NodeSlots = (NODE_COUNT < tse_pkg::NodeIdLimit) ?
                             NODE_COUNT : tse_pkg::NodeIdLimit;
  localparam int SlotW     = tse_pkg::NodeIdW + 1;
  localparam int CmdW      = $bits(tse_pkg::cmd_t);

  tse_pkg::cmd_t   cmd_in;
  logic [CmdW-1:0] cmd_raw;
  logic            q_empty;

  // drop adds for node numbers the table cannot hold
  always_comb begin
    cmd_in.node_id  = node_id_i;
    cmd_in.dep_mask = dep_mask_i;
    if (operation_i == tse_pkg::OpBuild) begin
      cmd_in.kind = tse_pkg::CMD_BUILD;
    end else if ({1'b0, node_id_i} < SlotW'(NodeSlots)) begin
      cmd_in.kind = tse_pkg::CMD_ADD;
    end else begin
      cmd_in.kind = tse_pkg::CMD_DROP;
    end
  end

  tse_fifo #(
    .WIDTH (CmdW),
    .DEPTH (DEPTH)
  ) u_cmd_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push),
    .wr_data_i  (cmd_in),
    .full_o     (full),
    .rd_data_o  (cmd_raw),
    .empty_o    (q_empty),
    .rd_pop_i   (cmd_pop_i)
  );

  assign cmd_valid_o = !q_empty;
  assign cmd_o       = cmd_raw;

endmodule

// ===== design/tse_sort.sv =====
// ----------------------------------------------------------------------------
// tse_sort
// Node table and Kahn sort sequencer with a LIFO of ready nodes.
// ----------------------------------------------------------------------------
`include "topological_sort_engine_top_defines.svh"

module tse_sort #(
  parameter int NODE_COUNT = tse_pkg::NodeCountDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  tse_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output tse_pkg::result_t res_o
);

  localparam int NodeSlots = (NODE_COUNT < tse_pkg::NodeIdLimit) ?
                             NODE_COUNT : tse_pkg::NodeIdLimit;
  localparam int IdxW      = (NodeSlots > 1) ? $clog2(NodeSlots) : 1;
  localparam int SpW       = $clog2(NodeSlots + 1);
  localparam int NodeIdW   = tse_pkg::NodeIdW;
  localparam int DepW      = tse_pkg::DepW;

  tse_pkg::sort_state_e state_q, state_d;

  logic [NodeSlots-1:0] present_q, present_d;
  logic [NodeSlots-1:0] done_q, done_d;
  logic [SpW-1:0]       sp_q, sp_d;
  logic [DepW-1:0]      dep_rows_q  [NodeSlots];
  logic [DepW-1:0]      work_rows_q [NodeSlots];
  logic [NodeIdW-1:0]   stack_q     [NodeSlots];

  logic [NodeSlots-1:0] row_zero;
  logic [NodeSlots-1:0] cand;
  logic                 cand_any;
  logic [IdxW-1:0]      pick_idx;
  logic [SpW-1:0]       sp_dec;
  logic [NodeIdW-1:0]   top_node;
  logic                 last_pop;
  logic                 add_new;
  logic                 build_start;
  logic                 push_step;
  logic                 pop_step;
  logic                 table_empty;
  logic [IdxW-1:0]      add_idx;

  always_comb begin
    for (int k = 0; k < NodeSlots; k++) begin
      row_zero[k] = (work_rows_q[k] == '0);
    end
  end

  assign cand     = present_q & ~done_q & row_zero;
  assign cand_any = |cand;

  // lowest ready node goes on the stack first
  always_comb begin
    pick_idx = '0;
    for (int k = NodeSlots - 1; k >= 0; k--) begin
      if (cand[k]) begin
        pick_idx = IdxW'(k);
      end
    end
  end

  assign sp_dec      = sp_q - SpW'(1);
  assign top_node    = stack_q[sp_dec[IdxW-1:0]];
  assign last_pop    = (done_q == present_q) && (sp_q == SpW'(1));
  assign table_empty = (present_q == '0);
  assign add_idx     = cmd_i.node_id[IdxW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tse_pkg::ST_IDLE: begin
        if (cmd_valid_i && cmd_i.kind == tse_pkg::CMD_BUILD && !table_empty) begin
          state_d = tse_pkg::ST_PUSH;
        end
      end
      tse_pkg::ST_PUSH: begin
        if (!cand_any) begin
          if (sp_q != '0) begin
            state_d = tse_pkg::ST_POP;
          end else if (done_q == present_q || !res_full_i) begin
            state_d = tse_pkg::ST_IDLE;
          end
        end
      end
      tse_pkg::ST_POP: begin
        if (!res_full_i) begin
          state_d = tse_pkg::ST_PUSH;
        end
      end
      default: state_d = tse_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop_o        = 1'b0;
    res_push_o       = 1'b0;
    res_o.order_node = '0;
    res_o.status     = tse_pkg::StatusSorted;
    res_o.last       = 1'b1;
    case (state_q)
      tse_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.kind == tse_pkg::CMD_BUILD && table_empty) begin
            cmd_pop_o    = !res_full_i;
            res_push_o   = !res_full_i;
            res_o.status = tse_pkg::StatusEmpty;
          end else begin
            cmd_pop_o = 1'b1;
          end
        end
      end
      tse_pkg::ST_PUSH: begin
        if (!cand_any && sp_q == '0 && done_q != present_q) begin
          res_push_o   = !res_full_i;
          res_o.status = tse_pkg::StatusUnresolved;
        end
      end
      tse_pkg::ST_POP: begin
        res_push_o       = !res_full_i;
        res_o.order_node = top_node;
        res_o.last       = last_pop;
      end
      default: ;
    endcase
  end

  assign add_new     = (state_q == tse_pkg::ST_IDLE) && cmd_pop_o &&
                       (cmd_i.kind == tse_pkg::CMD_ADD) && !present_q[add_idx];
  assign build_start = (state_q == tse_pkg::ST_IDLE) && cmd_pop_o &&
                       (cmd_i.kind == tse_pkg::CMD_BUILD) && !table_empty;
  assign push_step   = (state_q == tse_pkg::ST_PUSH) && cand_any;
  assign pop_step    = (state_q == tse_pkg::ST_POP) && !res_full_i;

  always_comb begin
    present_d = present_q;
    done_d    = done_q;
    sp_d      = sp_q;
    if (add_new) begin
      present_d[add_idx] = 1'b1;
    end
    if (build_start) begin
      done_d = '0;
      sp_d   = '0;
    end
    if (push_step) begin
      done_d[pick_idx] = 1'b1;
      sp_d             = sp_q + SpW'(1);
    end
    if (pop_step) begin
      sp_d = sp_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tse_pkg::ST_IDLE;
      present_q <= '0;
      done_q    <= '0;
      sp_q      <= '0;
    end else begin
      state_q   <= state_d;
      present_q <= present_d;
      done_q    <= done_d;
      sp_q      <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (add_new) begin
      dep_rows_q[add_idx] <= cmd_i.dep_mask;
    end
    if (push_step) begin
      stack_q[sp_q[IdxW-1:0]] <= NodeIdW'(pick_idx);
    end
    for (int k = 0; k < NodeSlots; k++) begin
      if (build_start) begin
        work_rows_q[k] <= present_q[k] ? dep_rows_q[k] : '0;
      end else if (pop_step) begin
        // clear the emitted node from every remaining row
        work_rows_q[k] <= work_rows_q[k] & ~(DepW'(1) << top_node);
      end
    end
  end

  `TSE_ASSERT_IMPL(a_sp_bound, 1'b1, sp_q <= SpW'(NodeSlots))
  `TSE_ASSERT_IMPL(a_res_space, res_push_o, !res_full_i)
  `TSE_ASSERT_NEXT(a_pop_dec, pop_step, sp_q == $past(sp_q) - SpW'(1))
  `TSE_ASSERT_IMPL(a_done_present, state_q != tse_pkg::ST_IDLE, (done_q & ~present_q) == '0)

endmodule

// ===== design/topological_sort_engine_top.sv =====
// ----------------------------------------------------------------------------
// topological_sort_engine_top
// Kahn topological sort over a bounded node table, queue style ports.
// ----------------------------------------------------------------------------
// Channel   Handshake        Payload
// input     push / full      operation_i, node_id_i, dep_mask_i
// result    pop / empty      order_node_o, status_o, last_o
//
// An add is taken while the engine is idle. A build first loads the working
// rows, then pushes each ready node onto the ready stack in turn, and for
// each node popped runs a scan for newly ready nodes plus the pop itself,
// with a closing scan; an empty table is answered with an empty status.
// The push/pop sequencer over the working rows sets these steps.
// Reset clears the present mask and control state; no clearing pass runs.
// A full result queue stalls the engine; a two-item command queue keeps
// taking input while the engine is busy.
// ----------------------------------------------------------------------------
module topological_sort_engine_top #(
  parameter int NODE_COUNT = tse_pkg::NodeCountDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic                         operation_i,
  input  logic [tse_pkg::NodeIdW-1:0]  node_id_i,
  input  logic [tse_pkg::DepW-1:0]     dep_mask_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [tse_pkg::NodeIdW-1:0]  order_node_o,
  output logic [tse_pkg::StatusW-1:0]  status_o,
  output logic                         last_o
);

  localparam int ResW = $bits(tse_pkg::result_t);

  logic             cmd_valid;
  tse_pkg::cmd_t    cmd;
  logic             cmd_pop;
  logic             res_full;
  logic             res_push;
  tse_pkg::result_t res_in;
  logic [ResW-1:0]  res_raw;
  tse_pkg::result_t res_out;

  tse_front #(
    .NODE_COUNT (NODE_COUNT),
    .DEPTH      (tse_pkg::CmdQueueDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .operation_i (operation_i),
    .node_id_i   (node_id_i),
    .dep_mask_i  (dep_mask_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  tse_sort #(
    .NODE_COUNT (NODE_COUNT)
  ) u_sort (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  tse_fifo #(
    .WIDTH (ResW),
    .DEPTH (tse_pkg::ResQueueDepth)
  ) u_res_q (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (res_push),
    .wr_data_i  (res_in),
    .full_o     (res_full),
    .rd_data_o  (res_raw),
    .empty_o    (empty),
    .rd_pop_i   (pop)
  );

  assign res_out      = res_raw;
  assign order_node_o = res_out.order_node;
  assign status_o     = res_out.status;
  assign last_o       = res_out.last;

endmodule
